// ===== design/oerq_pkg.sv =====
// oerq_pkg: types, codes and helper functions of the owned event ring queue
// used by oerq_slot_ram and owned_event_ring_queue; depends on nothing else

package oerq_pkg;

   localparam int DEF_RING_DEPTH    = 64;
   localparam int DEF_MAX_MSG_BYTES = 8;
   localparam int PEND_W            = 7;

   localparam logic [2:0] MODE_CLAIM   = 3'd0;
   localparam logic [2:0] MODE_RELEASE = 3'd1;
   localparam logic [2:0] MODE_PUSH    = 3'd2;
   localparam logic [2:0] MODE_POP     = 3'd3;
   localparam logic [2:0] MODE_DISCARD = 3'd4;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_ZERO_TOKEN  = 3'd1;
   localparam logic [2:0] ST_NOT_OWNER   = 3'd2;
   localparam logic [2:0] ST_BAD_SIZE    = 3'd3;
   localparam logic [2:0] ST_FULL        = 3'd4;
   localparam logic [2:0] ST_EMPTY       = 3'd5;
   localparam logic [2:0] ST_OTHER_OWNER = 3'd6;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] owner_token;
      logic [3:0]  msg_size;
      logic [63:0] msg_bytes;
      logic [63:0] frame_start;
      logic [31:0] sample_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] event_sequence;
      logic [63:0] event_frame_start;
      logic [63:0] event_frame;
      logic [31:0] event_offset;
      logic [3:0]  event_size;
      logic [63:0] event_bytes;
      logic [6:0]  pending_count;
      logic [63:0] current_owner;
      logic [31:0] dropped_count;
      logic [31:0] oversized_count;
      logic [31:0] duplicate_claim_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0] frame_start;
      logic [31:0] offset;
      logic [3:0]  size;
      logic [63:0] bytes;
   } slot_type;

   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      if (n >= 4'd8) begin
         m = '1;
      end else begin
         m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
      end
      return m;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

endpackage

// ===== design/owned_event_ring_queue.sv =====
// owned_event_ring_queue: top level, request decode, lock, counters and ring pointers
// depends on oerq_pkg and oerq_slot_ram

// One request is in work at a time. In the cycle of the transfer the slot
// memory is read at the read pointer; then the request is decoded against
// that data and, once the output register is free, the state and the slot
// memory are written back and the result is loaded into the output register.
// The next request is taken once the result sits in the output register, so
// the queue takes no new request before it is through with the last one; a
// stalled result holds the request in work until the output register frees.
// The slot memory has one write port and one registered read port.

module owned_event_ring_queue
   import oerq_pkg::*;
#(
   parameter int RING_DEPTH    = DEF_RING_DEPTH,
   parameter int MAX_MSG_BYTES = DEF_MAX_MSG_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
   localparam logic [3:0]       SIZE_MAX = 4'(MAX_MSG_BYTES);

   logic             busy_ff;
   req_type          item_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic [63:0]      rd_seq_ff, rd_seq_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      lock_ff, lock_in;
   logic [31:0]      drop_ff, drop_in;
   logic [31:0]      over_ff, over_in;
   logic [31:0]      dup_ff, dup_in;

   logic             accept;
   logic             finish;
   logic             slot_wr_en;
   slot_type         slot_wr;
   slot_type         slot_rd;
   rsp_type          rsp_in;
   logic             tok_zero;
   logic             is_full;

   assign accept    = req_valid && req_ready;
   assign finish    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign tok_zero  = (item_ff.owner_token == '0);
   assign is_full   = (cnt_ff == CNT_FULL);

   assign slot_wr.frame_start = item_ff.frame_start;
   assign slot_wr.offset      = item_ff.sample_offset;
   assign slot_wr.size        = item_ff.msg_size;
   assign slot_wr.bytes       = item_ff.msg_bytes & byte_mask(item_ff.msg_size);

   oerq_slot_ram #(
      .RING_DEPTH(RING_DEPTH)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_wr_en && finish),
      .wr_addr(wr_idx_ff),
      .wr_data(slot_wr),
      .rd_en  (accept),
      .rd_addr(rd_idx_ff),
      .rd_data(slot_rd)
   );

   always_comb begin
      rsp_in     = '0;
      rd_seq_in  = rd_seq_ff;
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      cnt_in     = cnt_ff;
      lock_in    = lock_ff;
      drop_in    = drop_ff;
      over_in    = over_ff;
      dup_in     = dup_ff;
      slot_wr_en = 1'b0;
      rsp_in.status = ST_OK;
      unique case (item_ff.mode)
         MODE_CLAIM: begin
            if (tok_zero) begin
               rsp_in.status = ST_ZERO_TOKEN;
            end else if (lock_ff == '0 || lock_ff == item_ff.owner_token) begin
               lock_in = item_ff.owner_token;
            end else begin
               dup_in        = sat_inc(dup_ff);
               rsp_in.status = ST_OTHER_OWNER;
            end
         end
         MODE_RELEASE: begin
            if (tok_zero) begin
               rsp_in.status = ST_ZERO_TOKEN;
            end else if (lock_ff == item_ff.owner_token) begin
               lock_in = '0;
            end else begin
               rsp_in.status = ST_NOT_OWNER;
            end
         end
         MODE_PUSH: begin
            if (tok_zero) begin
               rsp_in.status = ST_ZERO_TOKEN;
            end else if (lock_ff != item_ff.owner_token) begin
               rsp_in.status = ST_NOT_OWNER;
            end else if (item_ff.msg_size == '0 || item_ff.msg_size > SIZE_MAX) begin
               over_in       = sat_inc(over_ff);
               rsp_in.status = ST_BAD_SIZE;
            end else if (is_full) begin
               drop_in       = sat_inc(drop_ff);
               rsp_in.status = ST_FULL;
            end else begin
               slot_wr_en = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
               wr_idx_in  = (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + IDX_W'(1);
            end
         end
         MODE_POP: begin
            if (cnt_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.event_sequence    = rd_seq_ff;
               rsp_in.event_frame_start = slot_rd.frame_start;
               rsp_in.event_offset      = slot_rd.offset;
               rsp_in.event_frame       = slot_rd.frame_start + 64'(slot_rd.offset);
               rsp_in.event_size        = slot_rd.size;
               rsp_in.event_bytes       = slot_rd.bytes & byte_mask(slot_rd.size);
               rd_seq_in = rd_seq_ff + 64'd1;
               cnt_in    = cnt_ff - CNT_W'(1);
               rd_idx_in = (rd_idx_ff == IDX_LAST) ? '0 : rd_idx_ff + IDX_W'(1);
            end
         end
         MODE_DISCARD: begin
            rd_seq_in = rd_seq_ff + 64'(cnt_ff);
            rd_idx_in = wr_idx_ff;
            cnt_in    = '0;
         end
         default: begin
         end
      endcase
      rsp_in.pending_count         = PEND_W'(cnt_in);
      rsp_in.current_owner         = lock_in;
      rsp_in.dropped_count         = drop_in;
      rsp_in.oversized_count       = over_in;
      rsp_in.duplicate_claim_count = dup_in;
   end

   // request in work
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (finish) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // queue state, lock and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_seq_ff <= '0;
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         cnt_ff    <= '0;
         lock_ff   <= '0;
         drop_ff   <= '0;
         over_ff   <= '0;
         dup_ff    <= '0;
      end else if (finish) begin
         rd_seq_ff <= rd_seq_in;
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         cnt_ff    <= cnt_in;
         lock_ff   <= lock_in;
         drop_ff   <= drop_in;
         over_ff   <= over_in;
         dup_ff    <= dup_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("pending count above ring depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (finish && slot_wr_en) |-> !is_full)
      else $error("slot write into a full ring");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result without a request in work");

   a_lock_change: assert property (@(posedge clock) disable iff (reset)
      (lock_ff != $past(lock_ff)) |->
         (lock_ff == '0 || lock_ff == $past(item_ff.owner_token)))
      else $error("lock taken by a token that did not claim it");

endmodule

// ===== design/oerq_slot_ram.sv =====
// oerq_slot_ram: slot storage of the ring, one write and one registered read port
// depends on oerq_pkg for the slot type

module oerq_slot_ram
   import oerq_pkg::*;
#(
   parameter int RING_DEPTH = DEF_RING_DEPTH
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
   input  slot_type                      wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   output slot_type                      rd_data
);

   slot_type slot_mem_ff [RING_DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_owned_event_ring_queue.sv =====
// tb_owned_event_ring_queue: self-checking testbench of the owned event ring queue
// directed and random requests under sender gaps and receiver stalls, results
// checked field by field against an in-bench queue model; depends on oerq_pkg and owned_event_ring_queue

module tb_owned_event_ring_queue;
   import oerq_pkg::*;

   localparam int DEPTH      = DEF_RING_DEPTH;
   localparam int MAX_BYTES  = DEF_MAX_MSG_BYTES;
   localparam int N_ITEMS    = 2000;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_WAIT  = 20;

   typedef struct {
      req_type r;
      bit      drain;
   } req_entry_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   owned_event_ring_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   // queue model state
   logic [63:0] wr_seq;
   logic [63:0] rd_seq;
   logic [63:0] lock_token;
   logic [63:0] ring_frame  [DEPTH];
   logic [31:0] ring_offset [DEPTH];
   logic [3:0]  ring_size   [DEPTH];
   logic [63:0] ring_bytes  [DEPTH];
   logic [31:0] drops;
   logic [31:0] oversizes;
   logic [31:0] dup_claims;

   req_entry_type pending_req [$];
   rsp_type       expected_rsp [$];
   req_entry_type head;
   rsp_type       want;

   int n_accepted = 0;
   int n_total    = 0;
   int n_fail     = 0;

   // generator state
   logic [63:0] gen_owner;
   bit          drain_next;
   int          n_gen;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type     p;
      int unsigned idx;
      logic [63:0] keep;
      logic [63:0] diff;
      p = '0;
      p.status = ST_OK;
      case (r.mode)
         MODE_CLAIM: begin
            if (r.owner_token == '0) begin
               p.status = ST_ZERO_TOKEN;
            end else if (lock_token == '0 || lock_token == r.owner_token) begin
               lock_token = r.owner_token;
            end else begin
               if (dup_claims != 32'hFFFF_FFFF) dup_claims = dup_claims + 32'd1;
               p.status = ST_OTHER_OWNER;
            end
         end
         MODE_RELEASE: begin
            if (r.owner_token == '0) begin
               p.status = ST_ZERO_TOKEN;
            end else if (lock_token == r.owner_token) begin
               lock_token = '0;
            end else begin
               p.status = ST_NOT_OWNER;
            end
         end
         MODE_PUSH: begin
            if (r.owner_token == '0) begin
               p.status = ST_ZERO_TOKEN;
            end else if (lock_token != r.owner_token) begin
               p.status = ST_NOT_OWNER;
            end else if (r.msg_size == 4'd0 || r.msg_size > 4'(MAX_BYTES)) begin
               if (oversizes != 32'hFFFF_FFFF) oversizes = oversizes + 32'd1;
               p.status = ST_BAD_SIZE;
            end else if (wr_seq - rd_seq >= 64'(DEPTH)) begin
               if (drops != 32'hFFFF_FFFF) drops = drops + 32'd1;
               p.status = ST_FULL;
            end else begin
               idx = int'(wr_seq % 64'(DEPTH));
               keep = (r.msg_size >= 4'd8) ? '1 : ((64'd1 << (8 * r.msg_size)) - 64'd1);
               ring_frame[idx]  = r.frame_start;
               ring_offset[idx] = r.sample_offset;
               ring_size[idx]   = r.msg_size;
               ring_bytes[idx]  = r.msg_bytes & keep;
               wr_seq = wr_seq + 64'd1;
            end
         end
         MODE_POP: begin
            if (rd_seq == wr_seq) begin
               p.status = ST_EMPTY;
            end else begin
               idx = int'(rd_seq % 64'(DEPTH));
               p.event_sequence    = rd_seq;
               p.event_frame_start = ring_frame[idx];
               p.event_offset      = ring_offset[idx];
               p.event_frame       = ring_frame[idx] + 64'(ring_offset[idx]);
               p.event_size        = ring_size[idx];
               p.event_bytes       = ring_bytes[idx];
               rd_seq = rd_seq + 64'd1;
            end
         end
         MODE_DISCARD: begin
            rd_seq = wr_seq;
         end
         default: begin
         end
      endcase
      diff = wr_seq - rd_seq;
      p.pending_count         = (diff > 64'(DEPTH)) ? PEND_W'(DEPTH) : diff[PEND_W-1:0];
      p.current_owner         = lock_token;
      p.dropped_count         = drops;
      p.oversized_count       = oversizes;
      p.duplicate_claim_count = dup_claims;
      return p;
   endfunction

   task automatic add_item(input logic [2:0] mode, input logic [63:0] tok,
                           input logic [3:0] size, input logic [63:0] bytes,
                           input logic [63:0] fs, input logic [31:0] off);
      req_entry_type e;
      e.r.mode          = mode;
      e.r.owner_token   = tok;
      e.r.msg_size      = size;
      e.r.msg_bytes     = bytes;
      e.r.frame_start   = fs;
      e.r.sample_offset = off;
      e.drain           = drain_next;
      drain_next        = 1'b0;
      pending_req.push_back(e);
      if (mode <= MODE_DISCARD) n_gen++;
   endtask

   task automatic add_op(input logic [2:0] mode, input logic [63:0] tok);
      add_item(mode, tok, 4'($urandom_range(0, 15)), rand64(), rand64(), $urandom);
   endtask

   task automatic add_push(input logic [63:0] tok);
      logic [3:0] sz;
      if ($urandom_range(0, 99) < 88) begin
         sz = 4'($urandom_range(1, MAX_BYTES));
      end else if ($urandom_range(0, 1) == 0) begin
         sz = 4'd0;
      end else begin
         sz = 4'($urandom_range(MAX_BYTES + 1, 15));
      end
      add_item(MODE_PUSH, tok, sz, rand64(), rand64(), $urandom);
   endtask

   function automatic logic [63:0] other_token();
      logic [63:0] t;
      do t = rand64(); while (t == '0 || t == gen_owner);
      return t;
   endfunction

   task automatic take_ownership();
      if (gen_owner == '0) begin
         gen_owner = ($urandom_range(0, 7) == 0) ? 64'd1 : other_token();
         add_op(MODE_CLAIM, gen_owner);
      end
   endtask

   // driver
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_response(req_data));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_req.size() != 0 &&
                         !(pending_req[0].drain && expected_rsp.size() != 0)) begin
               head = pending_req.pop_front();
               req_valid <= 1'b1;
               req_data  <= head.r;
               if (burst_left <= 1) begin
                  if ($urandom_range(0, 9) == 0) begin
                     burst_left <= 200;
                     gap_left   <= 0;
                  end else begin
                     burst_left <= $urandom_range(1, 20);
                     gap_left   <= $urandom_range(0, 6);
                  end
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int stall_mode;
   int mode_timer;
   int phase_cnt;

   task automatic compare_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_mode <= 0;
         mode_timer <= 0;
         phase_cnt  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("rsp transfer with no expected result");
               n_fail++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("status", want.status, rsp_data.status);
               compare_field("event_sequence", want.event_sequence, rsp_data.event_sequence);
               compare_field("event_frame_start", want.event_frame_start,
                             rsp_data.event_frame_start);
               compare_field("event_frame", want.event_frame, rsp_data.event_frame);
               compare_field("event_offset", want.event_offset, rsp_data.event_offset);
               compare_field("event_size", want.event_size, rsp_data.event_size);
               compare_field("event_bytes", want.event_bytes, rsp_data.event_bytes);
               compare_field("pending_count", want.pending_count, rsp_data.pending_count);
               compare_field("current_owner", want.current_owner, rsp_data.current_owner);
               compare_field("dropped_count", want.dropped_count, rsp_data.dropped_count);
               compare_field("oversized_count", want.oversized_count,
                             rsp_data.oversized_count);
               compare_field("duplicate_claim_count", want.duplicate_claim_count,
                             rsp_data.duplicate_claim_count);
            end
         end
         phase_cnt <= phase_cnt + 1;
         if (mode_timer == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_timer <= $urandom_range(50, 300);
         end else begin
            mode_timer <= mode_timer - 1;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= (phase_cnt % 3 == 0);
            default: rsp_ready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] tok_a;
      logic [63:0] tok_b;
      int          pick;
      int          n;

      wr_seq     = '0;
      rd_seq     = '0;
      lock_token = '0;
      drops      = '0;
      oversizes  = '0;
      dup_claims = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ring_frame[i]  = '0;
         ring_offset[i] = '0;
         ring_size[i]   = '0;
         ring_bytes[i]  = '0;
      end
      gen_owner  = '0;
      drain_next = 1'b0;
      n_gen      = 0;
      tok_a      = '1;
      tok_b      = 64'd1;

      // directed
      add_op(MODE_POP, tok_a);
      add_op(MODE_CLAIM, '0);
      add_op(MODE_PUSH, tok_a);
      add_op(MODE_CLAIM, tok_a);
      add_op(MODE_CLAIM, tok_a);
      add_op(MODE_CLAIM, tok_b);
      add_op(MODE_RELEASE, tok_b);
      add_op(MODE_RELEASE, '0);
      add_op(MODE_PUSH, '0);
      add_op(MODE_PUSH, tok_b);
      add_item(MODE_PUSH, tok_a, 4'd0, rand64(), rand64(), $urandom);
      add_item(MODE_PUSH, tok_a, 4'(MAX_BYTES + 1), rand64(), rand64(), $urandom);
      add_item(MODE_PUSH, tok_a, 4'd15, '1, '1, '1);
      add_item(MODE_PUSH, tok_a, 4'(MAX_BYTES), '1, '1, '1);
      add_item(MODE_PUSH, tok_a, 4'd1, '1, rand64(), $urandom);
      add_item(MODE_PUSH, tok_a, 4'(MAX_BYTES), '0, '0, '0);
      add_op(MODE_POP, '0);
      add_op(MODE_POP, '0);
      add_op(MODE_POP, '0);
      add_op(MODE_POP, '0);
      add_item(MODE_PUSH, tok_a, 4'd4, rand64(), rand64(), $urandom);
      add_op(MODE_DISCARD, '0);
      add_op(MODE_POP, '0);
      add_op(3'd5, rand64());
      add_op(3'd6, rand64());
      add_op(3'd7, rand64());
      add_op(MODE_RELEASE, tok_a);

      // random episodes
      drain_next = 1'b1;
      while (n_gen < N_ITEMS) begin
         if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            take_ownership();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
            repeat (n) add_push(gen_owner);
         end else if (pick < 65) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
            repeat (n) add_op(MODE_POP, rand64());
         end else if (pick < 78) begin
            take_ownership();
            n = $urandom_range(1, 20);
            repeat (n) begin
               if ($urandom_range(0, 1) == 0) add_push(gen_owner);
               else add_op(MODE_POP, rand64());
            end
         end else if (pick < 88) begin
            case ($urandom_range(0, 5))
               0: begin
                  if (gen_owner != '0) add_op(MODE_RELEASE, gen_owner);
                  gen_owner = '0;
               end
               1: begin
                  take_ownership();
                  add_op(MODE_CLAIM, other_token());
               end
               2: add_op(MODE_RELEASE, other_token());
               3: add_push(other_token());
               4: begin
                  if (gen_owner != '0) add_op(MODE_RELEASE, gen_owner);
                  gen_owner = '0;
                  take_ownership();
               end
               default: begin
                  take_ownership();
                  add_op(MODE_CLAIM, gen_owner);
               end
            endcase
         end else if (pick < 92) begin
            add_op(MODE_DISCARD, rand64());
         end else begin
            case ($urandom_range(0, 3))
               0: add_op(3'($urandom_range(5, 7)), rand64());
               1: add_op(MODE_CLAIM, '0);
               2: add_op(MODE_RELEASE, '0);
               default: add_push('0);
            endcase
         end
      end
      n_total = pending_req.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (n_accepted < n_total);
      do @(negedge clock); while (expected_rsp.size() != 0);
      repeat (TAIL_WAIT) @(negedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsp.size());
         n_fail++;
      end
      if (n_fail == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
